>>> rtl/core/cwsq_pkg.sv
package cwsq_pkg;

    // Field widths of the channels and the configuration port.
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned DKEY_W     = 16;
    localparam int unsigned WKEY_W     = 13;
    localparam int unsigned MKEY_W     = 15;
    localparam int unsigned EPOCH_W    = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Default width of the internal send counters.
    localparam int unsigned COUNT_BITS_DEF = 16;

    // Step modes. The unused code behaves as a check.
    localparam logic [1:0] MODE_CHECK = 2'd0;
    localparam logic [1:0] MODE_SEND  = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // Block reasons, in priority order.
    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_DAILY   = 2'd1;
    localparam logic [1:0] REASON_WEEKLY  = 2'd2;
    localparam logic [1:0] REASON_MONTHLY = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DAILY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEEKLY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTHLY = 2'd2;

    // Time constants: local time is UTC+5; small epochs mean the clock is not synced.
    localparam logic [EPOCH_W:0]   LOCAL_OFFSET_S = 33'd18000;
    localparam logic [EPOCH_W-1:0] UNSYNCED_MAX   = 32'd1000;

    // One input item.
    typedef struct packed {
        logic [1:0]         mode;
        logic [EPOCH_W-1:0] epoch_seconds;
        logic [CNT_W-1:0]   stored_daily;
        logic [CNT_W-1:0]   stored_weekly;
        logic [CNT_W-1:0]   stored_monthly;
        logic [DKEY_W-1:0]  stored_day_key;
        logic [WKEY_W-1:0]  stored_week_key;
        logic [MKEY_W-1:0]  stored_month_key;
    } t_item_in;

    // One result item.
    typedef struct packed {
        logic               allowed;
        logic [1:0]         block_reason;
        logic               window_reset;
        logic [CNT_W-1:0]   sent_today;
        logic [CNT_W-1:0]   sent_this_week;
        logic [CNT_W-1:0]   sent_this_month;
        logic               snapshot_taken;
        logic [DKEY_W-1:0]  day_key_out;
        logic [WKEY_W-1:0]  week_key_out;
        logic [MKEY_W-1:0]  month_key_out;
    } t_result;

    // Snapshot part of an item.
    typedef struct packed {
        logic [CNT_W-1:0]   stored_daily;
        logic [CNT_W-1:0]   stored_weekly;
        logic [CNT_W-1:0]   stored_monthly;
        logic [DKEY_W-1:0]  stored_day_key;
        logic [WKEY_W-1:0]  stored_week_key;
        logic [MKEY_W-1:0]  stored_month_key;
    } t_snap;

    // Item with its calendar keys, handed from the date pipeline to the quota stage.
    typedef struct packed {
        logic [1:0]         mode;
        t_snap              snap;
        logic               synced;
        logic [DKEY_W-1:0]  day_key;
        logic [WKEY_W-1:0]  week_key;
        logic [MKEY_W-1:0]  month_key;
    } t_dated;

endpackage

>>> rtl/core/cwsq_item_if.sv
interface cwsq_item_if;
    import cwsq_pkg::*;

    logic     valid;
    logic     ready;
    t_item_in data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/cwsq_result_if.sv
interface cwsq_result_if;
    import cwsq_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/calendar_window_send_quota_top.sv
// Channel     Direction  Payload
// i_item      in         mode, epoch, snapshot counts and keys
// o_result    out        limit status, counters, snapshot flag, window keys
// i_cfg_*     in         limit registers, written by index
//
// One item is accepted every cycle unless a stalled result backs up the pipeline. An
// item passes the input register and seven calendar stages, then the result register.
// The calendar stages carry the multiplies of the date conversion; the window
// state is read and written in the result stage, so items never wait on each other.
// Reset is synchronous and clears the state, the limits and all valid bits.
// A stalled result holds its stage; stages behind it keep filling empty slots.
module calendar_window_send_quota_top #(
    parameter int unsigned COUNT_BITS = cwsq_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cwsq_item_if.sink                       i_item,
    cwsq_result_if.source                   o_result,
    input  logic                            i_cfg_we,
    input  logic [cwsq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cwsq_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import cwsq_pkg::*;

    logic   w_dt_valid;
    logic   w_dt_ready;
    t_dated w_dt;

    // Calendar keys for each item.
    cwsq_date u_date (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_in       (i_item.data),
        .o_dt_valid (w_dt_valid),
        .i_dt_ready (w_dt_ready),
        .o_dt       (w_dt)
    );

    // Window counters, limits and the result register.
    cwsq_quota #(
        .COUNT_BITS (COUNT_BITS)
    ) u_quota (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_dt_valid  (w_dt_valid),
        .o_dt_ready  (w_dt_ready),
        .i_dt        (w_dt),
        .o_res_valid (o_result.valid),
        .i_res_ready (o_result.ready),
        .o_res       (o_result.data)
    );

endmodule

>>> rtl/core/cwsq_date.sv
module cwsq_date (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cwsq_pkg::t_item_in i_in,
    output logic              o_dt_valid,
    input  logic              i_dt_ready,
    output cwsq_pkg::t_dated  o_dt
);
    import cwsq_pkg::*;

    localparam int unsigned NSTG = 8;

    // Reciprocals for exact division by constants: q = (x * M) >> K.
    // Day: the epoch sum is first shifted by 7, leaving a division by 675.
    localparam logic [26:0] M_DAY  = 27'(((64'd1 << 36) + 64'd674) / 64'd675);
    localparam logic [16:0] M_WEEK = 17'(((64'd1 << 19) + 64'd6) / 64'd7);
    localparam logic [18:0] M_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  M_100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] M_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    // Civil calendar constants. Within the 32-bit epoch range the era is 4 or 5.
    localparam int unsigned CIVIL_SHIFT = 719468;
    localparam int unsigned ERA_DAYS    = 146097;
    localparam int unsigned CENT_DAYS   = 36524;
    localparam logic [15:0] DAY_ERA5    = 16'(5 * ERA_DAYS - CIVIL_SHIFT);
    localparam logic [17:0] DOE_OFS4    = 18'(CIVIL_SHIFT - 4 * ERA_DAYS);
    localparam logic [17:0] DOE_OFS5    = 18'(5 * ERA_DAYS - CIVIL_SHIFT);
    localparam logic [11:0] YEAR_ERA4   = 12'(4 * 400);
    localparam logic [11:0] YEAR_ERA5   = 12'(5 * 400);

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_adv;
    logic [NSTG-1:0] w_vin;

    // Stage registers.
    t_item_in    r0_item;
    t_dated      r1_dt, r2_dt, r3_dt, r4_dt, r5_dt, r6_dt, r7_dt;
    logic [15:0] r1_day;
    logic [17:0] r2_doe, r3_doe, r4_doe;
    logic        r2_era5, r3_era5, r4_era5, r5_era5, r6_era5;
    logic [6:0]  r3_a;
    logic [1:0]  r3_bc;
    logic [8:0]  r4_yoe, r5_yoe, r6_yoe;
    logic [8:0]  r5_doy;
    logic [3:0]  r6_mp;

    // Stage logic.
    t_dated      w_dt1, w_dt2, w_dt7;
    logic [32:0] w_tloc;
    logic [25:0] w_x;
    logic [52:0] w_dprod;
    logic        w_era5;
    logic [17:0] w_doe;
    logic [15:0] w_d3;
    logic [32:0] w_wprod;
    logic [36:0] w_aprod;
    logic [1:0]  w_bc;
    logic [17:0] w_num;
    logic [36:0] w_yprod;
    logic [18:0] w_cprod;
    logic [17:0] w_ybase;
    logic [10:0] w_v;
    logic [22:0] w_mprod;
    logic [3:0]  w_m;
    logic [11:0] w_y;

    // Each stage moves when it is empty or the stage after it moves.
    always_comb begin
        w_adv[NSTG-1] = !r_v[NSTG-1] || i_dt_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end

    assign w_vin      = {r_v[NSTG-2:0], i_in_valid};
    assign o_in_ready = w_adv[0];
    assign o_dt_valid = r_v[NSTG-1];
    assign o_dt       = r7_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (w_adv & w_vin) | (~w_adv & r_v);
        end
    end

    // Stage 1: local day number.
    always_comb begin
        w_tloc  = {1'b0, r0_item.epoch_seconds} + LOCAL_OFFSET_S;
        w_x     = w_tloc[32:7];
        w_dprod = w_x * M_DAY;
        w_dt1.mode                  = r0_item.mode;
        w_dt1.snap.stored_daily     = r0_item.stored_daily;
        w_dt1.snap.stored_weekly    = r0_item.stored_weekly;
        w_dt1.snap.stored_monthly   = r0_item.stored_monthly;
        w_dt1.snap.stored_day_key   = r0_item.stored_day_key;
        w_dt1.snap.stored_week_key  = r0_item.stored_week_key;
        w_dt1.snap.stored_month_key = r0_item.stored_month_key;
        w_dt1.synced                = r0_item.epoch_seconds > UNSYNCED_MAX;
        w_dt1.day_key               = '0;
        w_dt1.week_key              = '0;
        w_dt1.month_key             = '0;
    end

    // Stage 2: day and week keys, era and day of era.
    always_comb begin
        w_era5  = r1_day >= DAY_ERA5;
        w_doe   = w_era5 ? (18'(r1_day) - DOE_OFS5) : (18'(r1_day) + DOE_OFS4);
        w_d3    = r1_day + 16'd3;
        w_wprod = w_d3 * M_WEEK;
        w_dt2          = r1_dt;
        w_dt2.day_key  = r1_day + 16'd1;
        w_dt2.week_key = w_wprod[31:19] + 13'd1;
    end

    // Stage 3: four-year and century corrections. The last day of an era cancels out.
    always_comb begin
        w_aprod = r2_doe * M_1460;
        w_bc    = 2'(r2_doe >= 18'(CENT_DAYS)) + 2'(r2_doe >= 18'(2 * CENT_DAYS))
                + 2'(r2_doe >= 18'(3 * CENT_DAYS));
    end

    // Stage 4: year of era.
    always_comb begin
        w_num   = r3_doe - 18'(r3_a) + 18'(r3_bc);
        w_yprod = w_num * M_365;
    end

    // Stage 5: day of year, counted from March.
    always_comb begin
        w_cprod = r4_yoe * M_100;
        w_ybase = 18'(r4_yoe) * 18'd365 + 18'(r4_yoe[8:2]) - 18'(w_cprod[17:16]);
    end

    // Stage 6: month index from March.
    always_comb begin
        w_v     = {r5_doy, 2'b00} + 11'(r5_doy) + 11'd2;
        w_mprod = w_v * M_153;
    end

    // Stage 7: civil month and year, then the month key.
    always_comb begin
        w_m = (r6_mp < 4'd10) ? (r6_mp + 4'd3) : (r6_mp - 4'd9);
        w_y = 12'(r6_yoe) + (r6_era5 ? YEAR_ERA5 : YEAR_ERA4) + 12'(w_m <= 4'd2);
        w_dt7           = r6_dt;
        w_dt7.month_key = 15'({w_y, 3'b000}) + 15'({w_y, 2'b00}) + 15'(w_m);
    end

    // Payload registers load whenever their stage moves.
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r0_item <= i_in;
        end
        if (w_adv[1]) begin
            r1_dt  <= w_dt1;
            r1_day <= w_dprod[51:36];
        end
        if (w_adv[2]) begin
            r2_dt   <= w_dt2;
            r2_doe  <= w_doe;
            r2_era5 <= w_era5;
        end
        if (w_adv[3]) begin
            r3_dt   <= r2_dt;
            r3_doe  <= r2_doe;
            r3_era5 <= r2_era5;
            r3_a    <= w_aprod[35:29];
            r3_bc   <= w_bc;
        end
        if (w_adv[4]) begin
            r4_dt   <= r3_dt;
            r4_doe  <= r3_doe;
            r4_era5 <= r3_era5;
            r4_yoe  <= w_yprod[35:27];
        end
        if (w_adv[5]) begin
            r5_dt   <= r4_dt;
            r5_yoe  <= r4_yoe;
            r5_era5 <= r4_era5;
            r5_doy  <= 9'(r4_doe - w_ybase);
        end
        if (w_adv[6]) begin
            r6_dt   <= r5_dt;
            r6_yoe  <= r5_yoe;
            r6_era5 <= r5_era5;
            r6_mp   <= w_mprod[22:19];
        end
        if (w_adv[7]) begin
            r7_dt <= w_dt7;
        end
    end

endmodule

>>> rtl/core/cwsq_quota.sv
module cwsq_quota #(
    parameter int unsigned COUNT_BITS = cwsq_pkg::COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cwsq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cwsq_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_dt_valid,
    output logic                             o_dt_ready,
    input  cwsq_pkg::t_dated                 i_dt,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output cwsq_pkg::t_result                o_res
);
    import cwsq_pkg::*;

    // Sums are wide enough for a full counter plus a 16-bit stored count.
    localparam int unsigned SUM_W = ((COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W) + 1;
    localparam logic [SUM_W-1:0] CNT_MAX = SUM_W'({COUNT_BITS{1'b1}});

    function automatic logic [COUNT_BITS-1:0] f_sat_add(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        logic [SUM_W-1:0] s;
        s = a + b;
        return (s > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : s[COUNT_BITS-1:0];
    endfunction

    // Limits.
    logic [CFG_DATA_W-1:0] r_lim_d, r_lim_w, r_lim_m;

    // Window state.
    logic [COUNT_BITS-1:0] r_cnt_d, r_cnt_w, r_cnt_m;
    logic [COUNT_BITS-1:0] n_cnt_d, n_cnt_w, n_cnt_m;
    logic [DKEY_W-1:0]     r_key_d, n_key_d;
    logic [WKEY_W-1:0]     r_key_w, n_key_w;
    logic [MKEY_W-1:0]     r_key_m, n_key_m;
    logic                  r_snap, n_snap;

    // Result register.
    logic                  r_res_valid;
    t_result               r_res, n_res;

    logic                  w_take;
    logic                  w_send, w_load;
    logic                  w_clr_d, w_clr_w, w_clr_m;
    logic [COUNT_BITS-1:0] w_base_d, w_base_w, w_base_m;
    logic [CNT_W-1:0]      w_add_d, w_add_w, w_add_m;
    logic [SUM_W-1:0]      w_wide_d, w_wide_w, w_wide_m;
    logic                  w_hit_d, w_hit_w, w_hit_m;
    logic [1:0]            w_reason;

    assign o_dt_ready  = !r_res_valid || i_res_ready;
    assign w_take      = i_dt_valid && o_dt_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_d <= '0;
            r_lim_w <= '0;
            r_lim_m <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DAILY:   r_lim_d <= i_cfg_wdata;
                CFG_WEEKLY:  r_lim_w <= i_cfg_wdata;
                CFG_MONTHLY: r_lim_m <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Key refresh, window clears, counter update and limit check for one item.
    always_comb begin
        w_send = (i_dt.mode == MODE_SEND);
        w_load = (i_dt.mode == MODE_LOAD) && !r_snap;

        // Only a send or an adopted snapshot with a synced clock refreshes the keys.
        n_key_d = (i_dt.synced && (w_send || w_load)) ? i_dt.day_key   : r_key_d;
        n_key_w = (i_dt.synced && (w_send || w_load)) ? i_dt.week_key  : r_key_w;
        n_key_m = (i_dt.synced && (w_send || w_load)) ? i_dt.month_key : r_key_m;

        // A send clears only windows that moved, and only once time was known before.
        w_clr_d = w_send && (r_key_d != '0) && (n_key_d != r_key_d);
        w_clr_w = w_send && (r_key_d != '0) && (n_key_w != r_key_w);
        w_clr_m = w_send && (r_key_d != '0) && (n_key_m != r_key_m);

        w_base_d = w_clr_d ? '0 : r_cnt_d;
        w_base_w = w_clr_w ? '0 : r_cnt_w;
        w_base_m = w_clr_m ? '0 : r_cnt_m;

        // A send adds one; a snapshot adds stored counts whose key matches.
        if (w_send) begin
            w_add_d = 16'd1;
            w_add_w = 16'd1;
            w_add_m = 16'd1;
        end else begin
            w_add_d = (w_load && i_dt.snap.stored_day_key == n_key_d)
                      ? i_dt.snap.stored_daily : '0;
            w_add_w = (w_load && i_dt.snap.stored_week_key == n_key_w)
                      ? i_dt.snap.stored_weekly : '0;
            w_add_m = (w_load && i_dt.snap.stored_month_key == n_key_m)
                      ? i_dt.snap.stored_monthly : '0;
        end

        n_cnt_d = f_sat_add(SUM_W'(w_base_d), SUM_W'(w_add_d));
        n_cnt_w = f_sat_add(SUM_W'(w_base_w), SUM_W'(w_add_w));
        n_cnt_m = f_sat_add(SUM_W'(w_base_m), SUM_W'(w_add_m));
        n_snap  = r_snap || w_load;

        w_wide_d = SUM_W'(n_cnt_d);
        w_wide_w = SUM_W'(n_cnt_w);
        w_wide_m = SUM_W'(n_cnt_m);

        // A zero limit is disabled; the daily limit wins over weekly over monthly.
        w_hit_d = (r_lim_d != '0) && (w_wide_d >= SUM_W'(r_lim_d));
        w_hit_w = (r_lim_w != '0) && (w_wide_w >= SUM_W'(r_lim_w));
        w_hit_m = (r_lim_m != '0) && (w_wide_m >= SUM_W'(r_lim_m));
        if (w_hit_d) begin
            w_reason = REASON_DAILY;
        end else if (w_hit_w) begin
            w_reason = REASON_WEEKLY;
        end else if (w_hit_m) begin
            w_reason = REASON_MONTHLY;
        end else begin
            w_reason = REASON_NONE;
        end

        n_res.allowed         = (w_reason == REASON_NONE);
        n_res.block_reason    = w_reason;
        n_res.window_reset    = w_clr_d || w_clr_w || w_clr_m;
        n_res.sent_today      = w_wide_d[CNT_W-1:0];
        n_res.sent_this_week  = w_wide_w[CNT_W-1:0];
        n_res.sent_this_month = w_wide_m[CNT_W-1:0];
        n_res.snapshot_taken  = n_snap;
        n_res.day_key_out     = n_key_d;
        n_res.week_key_out    = n_key_w;
        n_res.month_key_out   = n_key_m;
    end

    // State and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_d     <= '0;
            r_cnt_w     <= '0;
            r_cnt_m     <= '0;
            r_key_d     <= '0;
            r_key_w     <= '0;
            r_key_m     <= '0;
            r_snap      <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (w_take) begin
            r_cnt_d     <= n_cnt_d;
            r_cnt_w     <= n_cnt_w;
            r_cnt_m     <= n_cnt_m;
            r_key_d     <= n_key_d;
            r_key_w     <= n_key_w;
            r_key_m     <= n_key_m;
            r_snap      <= n_snap;
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= n_res;
        end
    end

endmodule

>>> rtl/core/cwsq_checker.sv
module cwsq_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  cwsq_pkg::t_result i_out_data
);
    import cwsq_pkg::*;

    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed while stalled");

    // The allowed flag and the block reason agree.
    a_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.allowed == (i_out_data.block_reason == REASON_NONE)))
        else $error("allowed flag disagrees with block reason");

    // A cleared window was counted once by the same send.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.window_reset) |->
            (i_out_data.sent_today == 16'd1 || i_out_data.sent_this_week == 16'd1 ||
             i_out_data.sent_this_month == 16'd1))
        else $error("window reset without a fresh count");

    // The three keys are known together or not at all.
    a_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (((i_out_data.day_key_out == '0) == (i_out_data.week_key_out == '0)) &&
             ((i_out_data.day_key_out == '0) == (i_out_data.month_key_out == '0))))
        else $error("window keys out of step");

    // No result is offered in the first cycle after reset.
    a_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind calendar_window_send_quota_top cwsq_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);

>>> dv/calendar_window_send_quota_top_tb.sv
`timescale 1ns / 1ps

module calendar_window_send_quota_top_tb;
    import cwsq_pkg::*;

    // The spare mode code has no name in the package; it behaves as a check.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam longint unsigned SECS_PER_DAY = 64'd86400;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned PHASE_ITEMS = 107;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    cwsq_item_if item_if ();
    cwsq_result_if result_if ();

    calendar_window_send_quota_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (result_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Items waiting to be offered, and quota results predicted for accepted items.
    t_item_in item_backlog[$];
    t_result  quota_due[$];
    int unsigned items_offered = 0;
    int unsigned items_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;

    // Idling control: steady is shared by the driver and the monitor; the hold counters pace the monitor.
    bit steady = 1'b0;
    int unsigned hold_asked = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;

    // Random walk of the wall clock used for well-formed send sequences.
    logic [31:0] wall;

    // Predicted limits, counters and window keys of the block.
    logic [15:0] lim_day = '0, lim_week = '0, lim_month = '0;
    logic [15:0] cnt_day = '0, cnt_week = '0, cnt_month = '0;
    logic [DKEY_W-1:0] key_day = '0;
    logic [WKEY_W-1:0] key_week = '0;
    logic [MKEY_W-1:0] key_month = '0;
    bit snap_done = 1'b0;

    always #2 i_clk = ~i_clk;

    // Month key from a day count since 1970, via the civil date of that day.
    function automatic logic [MKEY_W-1:0] month_key_for(longint unsigned days);
        longint unsigned z, era, doe, yoe, yr, doy, mp, mon;
        z = days + 719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        yr = yoe + era * 400;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        mon = (mp < 10) ? mp + 3 : mp - 9;
        if (mon <= 2) yr = yr + 1;
        return MKEY_W'(yr * 12 + mon);
    endfunction

    // Day, week and month keys of an epoch in local time.
    function automatic void calendar_keys(input logic [31:0] epoch,
                                          output logic [DKEY_W-1:0] kd,
                                          output logic [WKEY_W-1:0] kw,
                                          output logic [MKEY_W-1:0] km);
        longint unsigned d;
        d = (64'(epoch) + LOCAL_OFFSET_S) / SECS_PER_DAY;
        kd = DKEY_W'(d + 1);
        kw = WKEY_W'((d + 3) / 7 + 1);
        km = month_key_for(d);
    endfunction

    function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = 17'(a) + 17'(b);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // Applies one item to the predicted state and returns the expected result.
    function automatic t_result quota_step(t_item_in it);
        t_result r;
        logic [DKEY_W-1:0] pd;
        logic [WKEY_W-1:0] pw;
        logic [MKEY_W-1:0] pm;
        logic cleared;
        logic [1:0] why;
        cleared = 1'b0;
        if (it.mode == MODE_SEND) begin
            pd = key_day;
            pw = key_week;
            pm = key_month;
            if (it.epoch_seconds > UNSYNCED_MAX)
                calendar_keys(it.epoch_seconds, key_day, key_week, key_month);
            // Windows only roll over once a day key has been known before.
            if (pd != '0) begin
                if (key_day != pd) begin
                    cnt_day = '0;
                    cleared = 1'b1;
                end
                if (key_week != pw) begin
                    cnt_week = '0;
                    cleared = 1'b1;
                end
                if (key_month != pm) begin
                    cnt_month = '0;
                    cleared = 1'b1;
                end
            end
            cnt_day = sat_add(cnt_day, 16'd1);
            cnt_week = sat_add(cnt_week, 16'd1);
            cnt_month = sat_add(cnt_month, 16'd1);
        end else if (it.mode == MODE_LOAD && !snap_done) begin
            if (it.epoch_seconds > UNSYNCED_MAX)
                calendar_keys(it.epoch_seconds, key_day, key_week, key_month);
            if (it.stored_day_key == key_day) cnt_day = sat_add(cnt_day, it.stored_daily);
            if (it.stored_week_key == key_week) cnt_week = sat_add(cnt_week, it.stored_weekly);
            if (it.stored_month_key == key_month)
                cnt_month = sat_add(cnt_month, it.stored_monthly);
            snap_done = 1'b1;
        end
        // The first limit reached wins, in daily, weekly, monthly order.
        if (lim_day != '0 && cnt_day >= lim_day) why = REASON_DAILY;
        else if (lim_week != '0 && cnt_week >= lim_week) why = REASON_WEEKLY;
        else if (lim_month != '0 && cnt_month >= lim_month) why = REASON_MONTHLY;
        else why = REASON_NONE;
        r.allowed = (why == REASON_NONE);
        r.block_reason = why;
        r.window_reset = cleared;
        r.sent_today = cnt_day;
        r.sent_this_week = cnt_week;
        r.sent_this_month = cnt_month;
        r.snapshot_taken = snap_done;
        r.day_key_out = key_day;
        r.week_key_out = key_week;
        r.month_key_out = key_month;
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s got %0h want %0h",
                                    results_seen, name, got, want));
    endtask

    // Driver: offers queued items and predicts each one at its transfer.
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                quota_due.push_back(quota_step(item_if.data));
                items_accepted++;
            end
            if (!item_if.valid || item_if.ready) begin
                if (item_backlog.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
                    item_if.valid <= 1'b1;
                    item_if.data <= item_backlog.pop_front();
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and paces the result ready.
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                results_seen++;
                if (quota_due.size() == 0) begin
                    note_mismatch($sformatf("result %0d arrived with none expected",
                                            results_seen));
                end else begin
                    want = quota_due.pop_front();
                    check_field("allowed", result_if.data.allowed, want.allowed);
                    check_field("block_reason", result_if.data.block_reason, want.block_reason);
                    check_field("window_reset", result_if.data.window_reset, want.window_reset);
                    check_field("sent_today", result_if.data.sent_today, want.sent_today);
                    check_field("sent_this_week", result_if.data.sent_this_week,
                                want.sent_this_week);
                    check_field("sent_this_month", result_if.data.sent_this_month,
                                want.sent_this_month);
                    check_field("snapshot_taken", result_if.data.snapshot_taken,
                                want.snapshot_taken);
                    check_field("day_key_out", result_if.data.day_key_out, want.day_key_out);
                    check_field("week_key_out", result_if.data.week_key_out, want.week_key_out);
                    check_field("month_key_out", result_if.data.month_key_out,
                                want.month_key_out);
                end
            end
            // A requested hold keeps ready low long enough to back up the input.
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (hold_done != hold_asked) begin
                hold_done = hold_asked;
                hold_left = HOLD_CYCLES;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= steady || $urandom_range(99) >= 29;
            end
        end
    end

    function automatic logic [31:0] local_epoch(int unsigned days, int unsigned secs);
        return 32'(64'(days) * SECS_PER_DAY + secs - LOCAL_OFFSET_S);
    endfunction

    // An item of the given mode and epoch with random snapshot fields.
    function automatic t_item_in plain(logic [1:0] mode, logic [31:0] epoch);
        t_item_in it;
        it.mode = mode;
        it.epoch_seconds = epoch;
        it.stored_daily = 16'($urandom);
        it.stored_weekly = 16'($urandom);
        it.stored_monthly = 16'($urandom);
        it.stored_day_key = DKEY_W'($urandom);
        it.stored_week_key = WKEY_W'($urandom);
        it.stored_month_key = MKEY_W'($urandom);
        return it;
    endfunction

    // Mostly sends and checks along an advancing clock, with some noise.
    function automatic t_item_in random_item();
        t_item_in it;
        int unsigned pick;
        longint unsigned stride;
        it = plain(MODE_SEND, wall);
        pick = $urandom_range(99);
        if (pick < 55) begin
            it.mode = MODE_SEND;
        end else if (pick < 72) begin
            it.mode = MODE_CHECK;
        end else if (pick < 76) begin
            it.mode = MODE_SPARE;
        end else if (pick < 82) begin
            it.mode = MODE_LOAD;
            if ($urandom_range(1))
                calendar_keys(wall, it.stored_day_key, it.stored_week_key, it.stored_month_key);
        end else if (pick < 90) begin
            it.mode = 2'($urandom);
            it.epoch_seconds = $urandom_range(UNSYNCED_MAX);
        end else begin
            it.mode = 2'($urandom);
            it.epoch_seconds = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 65) stride = $urandom_range(3600);
        else if (pick < 87) stride = $urandom_range(2 * 86400);
        else if (pick < 96) stride = $urandom_range(10 * 86400);
        else stride = $urandom_range(45 * 86400);
        if (64'(wall) + stride > 64'hFFFF_FFFF) wall = $urandom_range(32'hF000_0000, 1001);
        else wall = 32'(64'(wall) + stride);
        return it;
    endfunction

    task automatic offer(t_item_in it);
        item_backlog.push_back(it);
        items_offered++;
    endtask

    task automatic wait_drained();
        while (items_accepted != items_offered || quota_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_DAILY: lim_day = val;
            CFG_WEEKLY: lim_week = val;
            default: lim_month = val;
        endcase
    endtask

    task automatic set_limits(logic [15:0] d, logic [15:0] w, logic [15:0] m);
        write_limit(CFG_DAILY, d);
        write_limit(CFG_WEEKLY, w);
        write_limit(CFG_MONTHLY, m);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase();
        wall = $urandom_range(32'hF000_0000, 1001);
        repeat (PHASE_ITEMS) offer(random_item());
        wait_drained();
    endtask

    // Stimulus sequence: directed items first, then random phases.
    initial begin : stimulus
        t_item_in it;
        logic [DKEY_W-1:0] kd;
        logic [WKEY_W-1:0] kw;
        logic [MKEY_W-1:0] km;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_DAILY;
        i_cfg_wdata = '0;
        item_if.valid = 1'b0;
        item_if.data = '0;
        result_if.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Unlimited quotas: key handling, snapshot and window rollover.
        set_limits(16'd0, 16'd0, 16'd0);
        it = plain(MODE_CHECK, 32'd0);
        it.stored_daily = '0;
        it.stored_weekly = '0;
        it.stored_monthly = '0;
        it.stored_day_key = '0;
        it.stored_week_key = '0;
        it.stored_month_key = '0;
        offer(it);
        it = plain(MODE_SPARE, 32'hFFFF_FFFF);
        it.stored_daily = '1;
        it.stored_weekly = '1;
        it.stored_monthly = '1;
        it.stored_day_key = '1;
        it.stored_week_key = '1;
        it.stored_month_key = '1;
        offer(it);
        // Sends before the clock is synced, then the first known keys.
        offer(plain(MODE_SEND, 32'd500));
        offer(plain(MODE_SEND, UNSYNCED_MAX));
        offer(plain(MODE_SEND, UNSYNCED_MAX + 1));
        // Snapshot: day and week keys match and the daily count saturates; the month key does not.
        calendar_keys(32'd43200, kd, kw, km);
        it = plain(MODE_LOAD, 32'd43200);
        it.stored_daily = 16'hFFFF;
        it.stored_weekly = 16'hFFFB;
        it.stored_monthly = 16'd7;
        it.stored_day_key = kd;
        it.stored_week_key = kw;
        it.stored_month_key = km + 1'b1;
        offer(it);
        // A second snapshot must change nothing.
        it.epoch_seconds = 32'hFFFF_FFFF;
        it.stored_month_key = km;
        offer(it);
        // Last second of the first local day, then the next day.
        offer(plain(MODE_SEND, 32'd68399));
        offer(plain(MODE_SEND, 32'd68400));
        offer(plain(MODE_CHECK, 32'd68400));
        // Monday, new month, leap day, year end, unsynced and far future sends.
        offer(plain(MODE_SEND, local_epoch(4, 0)));
        offer(plain(MODE_SEND, local_epoch(31, 0)));
        offer(plain(MODE_SEND, local_epoch(19782, 3600)));
        offer(plain(MODE_SEND, local_epoch(19783, 0)));
        offer(plain(MODE_SEND, local_epoch(20453, 86399)));
        offer(plain(MODE_SEND, local_epoch(20454, 0)));
        offer(plain(MODE_SEND, 32'd500));
        offer(plain(MODE_SEND, 32'hFFFF_FFFF));
        offer(plain(MODE_CHECK, UNSYNCED_MAX + 1));
        offer(plain(MODE_SEND, UNSYNCED_MAX + 1));
        wait_drained();

        // Each block reason in turn: daily, weekly, then monthly.
        set_limits(16'd2, 16'd3, 16'd4);
        offer(plain(MODE_SEND, local_epoch(100, 3600)));
        offer(plain(MODE_SEND, local_epoch(100, 7200)));
        offer(plain(MODE_SEND, local_epoch(101, 0)));
        offer(plain(MODE_SEND, local_epoch(102, 0)));
        wait_drained();

        // Typical limits, with the result side held off at the start.
        set_limits(16'd3, 16'd8, 16'd20);
        hold_asked++;
        run_phase();

        // Weekly limit only, with no idling on either side.
        set_limits(16'd0, 16'd5, 16'd0);
        steady = 1'b1;
        run_phase();
        steady = 1'b0;

        // Extreme limits.
        set_limits(16'hFFFF, 16'hFFFF, 16'd1);
        run_phase();

        // Random small limits and another long hold.
        set_limits(16'($urandom_range(12)), 16'($urandom_range(12)), 16'($urandom_range(12)));
        hold_asked++;
        run_phase();

        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("calendar_window_send_quota_top_tb: PASS");
        end else begin
            $display("calendar_window_send_quota_top_tb: FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #400000;
        $display("calendar_window_send_quota_top_tb: FAIL");
        $finish;
    end

endmodule
